>>> hdl/vr_pkg.sv
// ----------------------------------------------------------------------------
// vr_pkg
// Shared constants, the saturation result type and the clamp function used
// by the refraction datapath.
// ----------------------------------------------------------------------------
package vr_pkg;

	// Index ratio: unsigned Q4.16
	localparam int ETA_BITS = 20;
	localparam int ETA_FRAC = 16;

	// Working width for sums and rescaled products before clamping
	localparam int WIDE = 130;

	// Entries in the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Queue entry bits besides the six vector components:
	// eta, d, k, total reflection, saturation
	localparam int QE_EXTRA = ETA_BITS + 64 + 64 + 2;

	typedef struct packed {
		logic signed [63:0] v;
		logic               hit;
	} sat_t;

	// Clamp a wide signed value to a signed range of the given width
	function automatic sat_t sat_to(input logic signed [WIDE-1:0] x, input int unsigned bits);
		sat_t r;
		logic signed [WIDE-1:0] one_w;
		logic signed [WIDE-1:0] hi;
		logic signed [WIDE-1:0] lo;
		one_w = 1;
		hi = (one_w <<< (bits - 1)) - one_w;
		lo = ~hi;
		if (x > hi) begin
			r.v = 64'(hi);
			r.hit = 1'b1;
		end else if (x < lo) begin
			r.v = 64'(lo);
			r.hit = 1'b1;
		end else begin
			r.v = 64'(x);
			r.hit = 1'b0;
		end
		return r;
	endfunction

endpackage

>>> hdl/vr_ray_if.sv
// ----------------------------------------------------------------------------
// vr_ray_if
// Input channel: incident vector, surface normal and index ratio.
// ----------------------------------------------------------------------------
interface vr_ray_if #(parameter int COMPONENT_BITS = 32);
	logic                             valid;
	logic                             ready;
	logic signed [COMPONENT_BITS-1:0] incident_x;
	logic signed [COMPONENT_BITS-1:0] incident_y;
	logic signed [COMPONENT_BITS-1:0] incident_z;
	logic signed [COMPONENT_BITS-1:0] normal_x;
	logic signed [COMPONENT_BITS-1:0] normal_y;
	logic signed [COMPONENT_BITS-1:0] normal_z;
	logic [19:0]                      index_ratio;

	modport source (
		output valid, incident_x, incident_y, incident_z,
		output normal_x, normal_y, normal_z, index_ratio,
		input  ready
	);
	modport sink (
		input  valid, incident_x, incident_y, incident_z,
		input  normal_x, normal_y, normal_z, index_ratio,
		output ready
	);
endinterface

>>> hdl/vr_result_if.sv
// ----------------------------------------------------------------------------
// vr_result_if
// Output channel: refracted vector and status flags.
// ----------------------------------------------------------------------------
interface vr_result_if #(parameter int COMPONENT_BITS = 32);
	logic                             valid;
	logic                             ready;
	logic signed [COMPONENT_BITS-1:0] refracted_x;
	logic signed [COMPONENT_BITS-1:0] refracted_y;
	logic signed [COMPONENT_BITS-1:0] refracted_z;
	logic                             total_reflection;
	logic                             saturated;

	modport source (
		output valid, refracted_x, refracted_y, refracted_z,
		output total_reflection, saturated,
		input  ready
	);
	modport sink (
		input  valid, refracted_x, refracted_y, refracted_z,
		input  total_reflection, saturated,
		output ready
	);
endinterface

>>> hdl/vr_mul.sv
// ----------------------------------------------------------------------------
// vr_mul
// Two-stage signed multiplier: four half-width partial products in the
// first stage, their aligned sum in the second.
// ----------------------------------------------------------------------------
module vr_mul #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p
);

	localparam int HA = AW / 2;
	localparam int HB = BW / 2;
	localparam int PW = AW + BW;

	logic [HA-1:0]                     al;
	logic signed [AW-HA-1:0]           ah;
	logic [HB-1:0]                     bl;
	logic signed [BW-HB-1:0]           bh;
	logic signed [HA+HB+1:0]           ll_s1;
	logic signed [HA+BW-HB:0]          lh_s1;
	logic signed [AW-HA+HB:0]          hl_s1;
	logic signed [AW-HA+BW-HB-1:0]     hh_s1;
	logic signed [PW-1:0]              p_s2;

	// split operands into low (unsigned) and high (signed) halves
	assign al = a[HA-1:0];
	assign ah = a[AW-1:HA];
	assign bl = b[HB-1:0];
	assign bh = b[BW-1:HB];

	// form partial products
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= $signed({1'b0, al}) * $signed({1'b0, bl});
			lh_s1 <= $signed({1'b0, al}) * bh;
			hl_s1 <= ah * $signed({1'b0, bl});
			hh_s1 <= ah * bh;
		end
	end

	// align and sum partial products: low A with high B sits at HB,
	// high A with low B sits at HA
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= PW'(ll_s1) + (PW'(lh_s1) <<< HB) + (PW'(hl_s1) <<< HA)
				+ (PW'(hh_s1) <<< (HA + HB));
		end
	end

	assign p = p_s2;

endmodule

>>> hdl/vr_sqrt.sv
// ----------------------------------------------------------------------------
// vr_sqrt
// Pipelined integer square root, one result bit per stage (restoring form).
// One radicand per cycle while en is high.
// ----------------------------------------------------------------------------
module vr_sqrt #(
	parameter int RW = 40
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*RW-1:0] rad,
	output logic [RW-1:0]   root
);

	logic [RW+1:0] rem_s  [0:RW];
	logic [RW-1:0] root_s [0:RW];
	logic [2*RW-1:0] rad_s [0:RW];

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = rad;

	for (genvar j = 1; j <= RW; j++) begin : g_step
		logic [RW+1:0] cur;
		logic [RW+1:0] trial;
		logic          take;

		// bring down two radicand bits and try the next root bit
		always_comb begin
			cur   = {rem_s[j-1][RW-1:0], rad_s[j-1][2*RW-1:2*RW-2]};
			trial = {root_s[j-1], 2'b01};
			take  = (cur >= trial);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= take ? (cur - trial) : cur;
				root_s[j] <= {root_s[j-1][RW-2:0], take};
				rad_s[j]  <= rad_s[j-1] << 2;
			end
		end
	end

	assign root = root_s[RW];

endmodule

>>> hdl/vr_queue.sv
// ----------------------------------------------------------------------------
// vr_queue
// Small register queue between the front and back pipelines.
// ----------------------------------------------------------------------------
module vr_queue import vr_pkg::*; #(
	parameter int W = 342
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic         empty,
	output logic [W-1:0] rdata
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	logic [W-1:0] mem [QUEUE_DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   cnt_q;

	// store incoming entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= wdata;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign full  = (cnt_q == (AW+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem[rd_q];

endmodule

>>> hdl/vr_front.sv
// ----------------------------------------------------------------------------
// vr_front
// Front pipeline: dot product, d^2, eta^2 (1 - d^2) and k, then the
// total reflection decision. Ten stages; hands entries to the queue.
// ----------------------------------------------------------------------------
module vr_front import vr_pkg::*; #(
	parameter int CW = 32,
	parameter int FW = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	vr_ray_if.sink                     ray,
	output logic                       q_push,
	output logic [6*CW+QE_EXTRA-1:0]   q_data,
	input  logic                       q_full
);

	localparam int NS = 10;
	localparam logic signed [63:0] ONE = 64'sd1 <<< FW;

	typedef struct packed {
		logic [2:0][CW-1:0]  inc;
		logic [2:0][CW-1:0]  nrm;
		logic [ETA_BITS-1:0] eta;
		logic [2*ETA_BITS-1:0] eta2;
		logic signed [63:0]  d;
		logic signed [63:0]  v;
		logic                sat;
	} fc_t;

	typedef struct packed {
		logic [2:0][CW-1:0]  inc;
		logic [2:0][CW-1:0]  nrm;
		logic [ETA_BITS-1:0] eta;
		logic signed [63:0]  d;
		logic signed [63:0]  k;
		logic                tir;
		logic                sat;
	} qe_t;

	fc_t  fc_s [1:NS];
	logic [NS:1] v_s;
	logic en;

	logic signed [2*CW-1:0] dot_p [3];
	logic signed [127:0]    dd_p;
	logic signed [2*ETA_BITS+64:0] ut_p;

	logic signed [WIDE-1:0] acc;
	sat_t d_r;
	sat_t dd_r;
	sat_t u_r;
	sat_t k_r;
	logic signed [63:0] t_n;
	qe_t qe;

	// stall the whole front while the last stage holds and the queue is full
	assign en        = !v_s[NS] || !q_full;
	assign ray.ready = en;
	assign q_push    = v_s[NS] && !q_full;

	vr_mul #(.AW(CW), .BW(CW)) u_dot_x (
		.clk(clk), .en(en), .a(ray.incident_x), .b(ray.normal_x), .p(dot_p[0]));
	vr_mul #(.AW(CW), .BW(CW)) u_dot_y (
		.clk(clk), .en(en), .a(ray.incident_y), .b(ray.normal_y), .p(dot_p[1]));
	vr_mul #(.AW(CW), .BW(CW)) u_dot_z (
		.clk(clk), .en(en), .a(ray.incident_z), .b(ray.normal_z), .p(dot_p[2]));

	vr_mul #(.AW(64), .BW(64)) u_dd (
		.clk(clk), .en(en), .a(fc_s[3].d), .b(fc_s[3].d), .p(dd_p));

	vr_mul #(.AW(2*ETA_BITS+1), .BW(64)) u_ut (
		.clk(clk), .en(en), .a($signed({1'b0, fc_s[6].eta2})), .b(fc_s[6].v), .p(ut_p));

	// rescale and clamp the intermediates
	always_comb begin
		acc  = WIDE'(dot_p[0]) + WIDE'(dot_p[1]) + WIDE'(dot_p[2]);
		d_r  = sat_to(acc >>> FW, 64);
		dd_r = sat_to(WIDE'(dd_p) >>> FW, 64);
		t_n  = ONE - dd_r.v;
		u_r  = sat_to(WIDE'(ut_p) >>> (2 * ETA_FRAC), 64);
		k_r  = sat_to(WIDE'(ONE) - WIDE'(fc_s[9].v), 64);
	end

	// advance the payload along the stages
	always_ff @(posedge clk) begin
		if (en) begin
			fc_s[1].inc  <= {ray.incident_z, ray.incident_y, ray.incident_x};
			fc_s[1].nrm  <= {ray.normal_z, ray.normal_y, ray.normal_x};
			fc_s[1].eta  <= ray.index_ratio;
			fc_s[1].eta2 <= (2*ETA_BITS)'(ray.index_ratio) * (2*ETA_BITS)'(ray.index_ratio);
			fc_s[1].d    <= '0;
			fc_s[1].v    <= '0;
			fc_s[1].sat  <= 1'b0;
			for (int j = 2; j <= NS; j++) begin
				fc_s[j] <= fc_s[j-1];
			end
			fc_s[3].d    <= d_r.v;
			fc_s[3].sat  <= d_r.hit;
			fc_s[6].v    <= t_n;
			fc_s[6].sat  <= fc_s[5].sat | dd_r.hit;
			fc_s[9].v    <= u_r.v;
			fc_s[9].sat  <= fc_s[8].sat | u_r.hit;
			fc_s[10].v   <= k_r.v;
			fc_s[10].sat <= fc_s[9].sat | k_r.hit;
		end
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[NS-1:1], ray.valid};
		end
	end

	// pack the queue entry
	always_comb begin
		qe.inc = fc_s[NS].inc;
		qe.nrm = fc_s[NS].nrm;
		qe.eta = fc_s[NS].eta;
		qe.d   = fc_s[NS].d;
		qe.k   = fc_s[NS].v;
		qe.tir = fc_s[NS].v[63];
		qe.sat = fc_s[NS].sat;
	end

	assign q_data = qe;

endmodule

>>> hdl/vr_back.sv
// ----------------------------------------------------------------------------
// vr_back
// Back pipeline: sqrt(k), c = eta*d + sqrt(k), and the refracted vector
// eta*I - c*N, clamped, into the output register.
// ----------------------------------------------------------------------------
module vr_back import vr_pkg::*; #(
	parameter int CW = 32,
	parameter int FW = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [6*CW+QE_EXTRA-1:0] q_data,
	input  logic                     q_empty,
	output logic                     q_pop,
	vr_result_if.source              result
);

	localparam int RW = (64 + FW) / 2;
	localparam int LB = RW + 4;
	localparam int AXW = CW + ETA_BITS + 1 - ETA_FRAC;

	typedef struct packed {
		logic [2:0][CW-1:0]  inc;
		logic [2:0][CW-1:0]  nrm;
		logic [ETA_BITS-1:0] eta;
		logic signed [63:0]  d;
		logic signed [63:0]  k;
		logic                tir;
		logic                sat;
	} qe_t;

	typedef struct packed {
		logic [2:0][CW-1:0]  nrm;
		logic [2:0][AXW-1:0] ax;
		logic signed [63:0]  m;
		logic signed [63:0]  c;
		logic                tir;
		logic                sat;
	} bc_t;

	qe_t hd;
	bc_t bc_s [1:LB-1];
	logic [LB:1] v_s;
	logic en;

	logic signed [ETA_BITS:0] eta_s;
	logic signed [CW+ETA_BITS:0] ei_p [3];
	logic signed [ETA_BITS+64:0] ed_p;
	logic signed [63+CW:0] cn_p [3];
	logic [2*RW-1:0] rad;
	logic [RW-1:0]   root;

	sat_t m_r;
	sat_t c_r;
	sat_t o_r [3];
	logic signed [WIDE-1:0] diff [3];

	logic [2:0][CW-1:0] r_q;
	logic tir_q;
	logic sat_q;

	assign hd    = q_data;
	assign en    = !v_s[LB] || result.ready;
	assign q_pop = !q_empty && en;
	assign eta_s = $signed({1'b0, hd.eta});
	assign rad   = {{(2*RW-63){1'b0}}, hd.k[62:0]} << FW;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		vr_mul #(.AW(ETA_BITS+1), .BW(CW)) u_ei (
			.clk(clk), .en(en), .a(eta_s), .b($signed(hd.inc[i])), .p(ei_p[i]));
		vr_mul #(.AW(64), .BW(CW)) u_cn (
			.clk(clk), .en(en), .a(bc_s[RW+1].c), .b($signed(bc_s[RW+1].nrm[i])),
			.p(cn_p[i]));
	end

	vr_mul #(.AW(ETA_BITS+1), .BW(64)) u_ed (
		.clk(clk), .en(en), .a(eta_s), .b(hd.d), .p(ed_p));

	vr_sqrt #(.RW(RW)) u_sqrt (
		.clk(clk), .en(en), .rad(rad), .root(root));

	// form m, c and the clamped output components
	always_comb begin
		m_r = sat_to(WIDE'(ed_p) >>> ETA_FRAC, 64);
		c_r = sat_to(WIDE'(bc_s[RW].m) + WIDE'($signed({1'b0, root})), 64);
		for (int i = 0; i < 3; i++) begin
			diff[i] = WIDE'($signed(bc_s[LB-1].ax[i])) - (WIDE'(cn_p[i]) >>> FW);
			o_r[i]  = sat_to(diff[i], CW);
		end
	end

	// advance the payload along the stages
	always_ff @(posedge clk) begin
		if (en) begin
			bc_s[1].nrm <= hd.nrm;
			bc_s[1].ax  <= '0;
			bc_s[1].m   <= '0;
			bc_s[1].c   <= '0;
			bc_s[1].tir <= hd.tir;
			bc_s[1].sat <= hd.sat;
			for (int j = 2; j <= LB-1; j++) begin
				bc_s[j] <= bc_s[j-1];
			end
			for (int i = 0; i < 3; i++) begin
				bc_s[3].ax[i] <= AXW'(ei_p[i] >>> ETA_FRAC);
			end
			bc_s[3].m      <= m_r.v;
			bc_s[3].sat    <= bc_s[2].sat | m_r.hit;
			bc_s[RW+1].c   <= c_r.v;
			bc_s[RW+1].sat <= bc_s[RW].sat | c_r.hit;
		end
	end

	// load the output register; zero vector on total reflection
	always_ff @(posedge clk) begin
		if (en) begin
			tir_q <= bc_s[LB-1].tir;
			if (bc_s[LB-1].tir) begin
				r_q   <= '0;
				sat_q <= 1'b0;
			end else begin
				for (int i = 0; i < 3; i++) begin
					r_q[i] <= CW'(o_r[i].v);
				end
				sat_q <= bc_s[LB-1].sat | o_r[0].hit | o_r[1].hit | o_r[2].hit;
			end
		end
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[LB-1:1], !q_empty};
		end
	end

	assign result.valid            = v_s[LB];
	assign result.refracted_x      = r_q[0];
	assign result.refracted_y      = r_q[1];
	assign result.refracted_z      = r_q[2];
	assign result.total_reflection = tir_q;
	assign result.saturated        = sat_q;

endmodule

>>> hdl/vector_refraction.sv
// ----------------------------------------------------------------------------
// vector_refraction
// Refracts an incident vector at a surface with normal N and index ratio
// eta: R = eta*I - (eta*d + sqrt(k))*N, with d = I.N and
// k = 1 - eta^2 (1 - d^2); k < 0 gives total reflection and a zero vector.
//
// Usage:
//   ray    - valid/ready input; one transfer carries I, N and eta.
//   result - valid/ready output; one transfer per input item, in order.
// Data passes through the ten-stage front, the queue and the
// bit-per-stage square root in the back. Throughput is one item per
// cycle while result is ready. The front and back are split by a
// four-entry queue: when result is stalled the back holds, the queue
// fills, and only then does ray.ready drop. Reset clears all valid bits
// and the queue; no data state survives between items.
// ----------------------------------------------------------------------------
module vector_refraction import vr_pkg::*; #(
	parameter int COMPONENT_BITS = 32,
	parameter int FRACTION_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	vr_ray_if.sink      ray,
	vr_result_if.source result
);

	localparam int QW = 6 * COMPONENT_BITS + QE_EXTRA;

	logic          q_push;
	logic          q_pop;
	logic          q_full;
	logic          q_empty;
	logic [QW-1:0] q_wdata;
	logic [QW-1:0] q_rdata;

	vr_front #(.CW(COMPONENT_BITS), .FW(FRACTION_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .ray(ray),
		.q_push(q_push), .q_data(q_wdata), .q_full(q_full));

	vr_queue #(.W(QW)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .wdata(q_wdata), .full(q_full),
		.pop(q_pop), .empty(q_empty), .rdata(q_rdata));

	vr_back #(.CW(COMPONENT_BITS), .FW(FRACTION_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_data(q_rdata), .q_empty(q_empty), .q_pop(q_pop),
		.result(result));

endmodule

>>> tb/sv/vector_refraction_checker.sv
// ----------------------------------------------------------------------------
// vector_refraction_checker
// Watches the ray and result channels, predicts the refracted vector and
// flags for every ray transfer, and compares each result transfer in order.
// ----------------------------------------------------------------------------
module vector_refraction_checker import vr_pkg::*; #(
	parameter int COMPONENT_BITS = 32,
	parameter int FRACTION_BITS  = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	vr_ray_if.sink     ray,
	vr_result_if.sink  result,
	output int         fail_count,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [COMPONENT_BITS-1:0] comp_t;
	typedef logic signed [WIDE-1:0] wide_t;

	typedef struct {
		comp_t rx, ry, rz;
		logic  tir;
		logic  sat;
	} refraction_t;

	refraction_t expected_q[$];

	// Clamp to a signed range and record whether a clamp took place
	function automatic wide_t clamp(input wide_t x, input int bits, inout logic hit);
		wide_t hi, lo;
		hi = (wide_t'(1) <<< (bits - 1)) - 1;
		lo = ~hi;
		if (x > hi) begin
			hit = 1'b1;
			return hi;
		end
		if (x < lo) begin
			hit = 1'b1;
			return lo;
		end
		return x;
	endfunction

	function automatic wide_t isqrt(input wide_t x);
		logic [127:0] root, cand;
		root = '0;
		for (int b = 63; b >= 0; b--) begin
			cand = root | (128'(1) << b);
			if (cand * cand <= 128'(x)) root = cand;
		end
		return wide_t'(root);
	endfunction

	function automatic refraction_t refract(input comp_t ix, iy, iz, nx, ny, nz,
			input logic [19:0] eta_bits);
		refraction_t r;
		wide_t iv[3], nv[3], acc, eta, one, d, dd, t, u, k, s, m, c, a, b;
		logic hit;
		hit = 1'b0;
		iv[0] = ix; iv[1] = iy; iv[2] = iz;
		nv[0] = nx; nv[1] = ny; nv[2] = nz;
		eta = wide_t'({1'b0, eta_bits});
		one = wide_t'(1) <<< FRACTION_BITS;
		acc = 0;
		for (int i = 0; i < 3; i++) acc += iv[i] * nv[i];
		d = clamp(acc >>> FRACTION_BITS, 64, hit);
		dd = clamp((d * d) >>> FRACTION_BITS, 64, hit);
		t = one - dd;
		u = clamp((eta * eta * t) >>> (2 * ETA_FRAC), 64, hit);
		k = clamp(one - u, 64, hit);
		if (k < 0) begin
			r.rx = '0; r.ry = '0; r.rz = '0;
			r.tir = 1'b1;
			r.sat = 1'b0;
			return r;
		end
		s = isqrt(k <<< FRACTION_BITS);
		m = clamp((eta * d) >>> ETA_FRAC, 64, hit);
		c = clamp(m + s, 64, hit);
		for (int i = 0; i < 3; i++) begin
			a = (eta * iv[i]) >>> ETA_FRAC;
			b = (c * nv[i]) >>> FRACTION_BITS;
			nv[i] = clamp(a - b, COMPONENT_BITS, hit);
		end
		r.rx = comp_t'(nv[0]); r.ry = comp_t'(nv[1]); r.rz = comp_t'(nv[2]);
		r.tir = 1'b0;
		r.sat = hit;
		return r;
	endfunction

	// Predict on ray transfers, compare on result transfers
	always @(posedge clk or negedge arst_n) begin
		refraction_t want;
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (ray.valid && ray.ready)
				expected_q.push_back(refract(ray.incident_x, ray.incident_y,
					ray.incident_z, ray.normal_x, ray.normal_y, ray.normal_z,
					ray.index_ratio));
			if (result.valid && result.ready) begin
				if (expected_q.size() == 0) begin
					$error("result transfer with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					if (result.refracted_x !== want.rx || result.refracted_y !== want.ry ||
							result.refracted_z !== want.rz ||
							result.total_reflection !== want.tir ||
							result.saturated !== want.sat)
						fail_count <= fail_count + 1;
					if (result.refracted_x !== want.rx)
						$error("refracted_x expected %0d got %0d", want.rx, result.refracted_x);
					if (result.refracted_y !== want.ry)
						$error("refracted_y expected %0d got %0d", want.ry, result.refracted_y);
					if (result.refracted_z !== want.rz)
						$error("refracted_z expected %0d got %0d", want.rz, result.refracted_z);
					if (result.total_reflection !== want.tir)
						$error("total_reflection expected %0b got %0b", want.tir,
							result.total_reflection);
					if (result.saturated !== want.sat)
						$error("saturated expected %0b got %0b", want.sat, result.saturated);
				end
			end
			pending <= expected_q.size();
		end
	end
endmodule

>>> tb/sv/vector_refraction_tb.sv
// ----------------------------------------------------------------------------
// vector_refraction_tb
// Drives directed and random rays into the refraction block with random
// idle bursts on both channels; a checker beside the block predicts and
// compares every result.
// ----------------------------------------------------------------------------
module vector_refraction_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_RANDOM = 1130;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic signed [31:0] ONE = 32'sh0001_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count, pending;
	int cycles = 0;
	bit calm = 1'b0;

	vr_ray_if    ray();
	vr_result_if result();

	vector_refraction dut (.clk(clk), .arst_n(arst_n), .ray(ray), .result(result));
	vector_refraction_checker chk (.clk(clk), .arst_n(arst_n), .ray(ray), .result(result),
		.fail_count(fail_count), .pending(pending));

	always #5 clk = ~clk;

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("vector_refraction_tb NOT OK");
			$finish;
		end
	end

	// Stall the result side in bursts
	initial begin
		int n;
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 10);
				result.ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			result.ready <= 1'b1;
		end
	end

	function automatic logic [31:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'h8000_0000 | ($urandom() & 32'h1);
			2: return 32'h7FFF_FFFF ^ ($urandom() & 32'h1);
			default: return 32'(int'($urandom_range(0, 2 * 65536)) - 65536);
		endcase
	endfunction

	task automatic send(input logic [31:0] ix, iy, iz, nx, ny, nz, input logic [19:0] eta);
		ray.valid <= 1'b1;
		ray.incident_x <= ix; ray.incident_y <= iy; ray.incident_z <= iz;
		ray.normal_x <= nx; ray.normal_y <= ny; ray.normal_z <= nz;
		ray.index_ratio <= eta;
		@(posedge clk);
		while (!ray.ready) @(posedge clk);
		@(negedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			ray.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
	endtask

	initial begin
		logic [31:0] nz;
		ray.valid = 1'b0;
		{ray.incident_x, ray.incident_y, ray.incident_z} = '0;
		{ray.normal_x, ray.normal_y, ray.normal_z} = '0;
		ray.index_ratio = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: normal incidence, grazing, total reflection, extremes
		send(0, 0, -ONE, 0, 0, ONE, 20'h10000);
		send(0, 0, 0, 0, 0, 0, 20'h0);
		send(ONE, 0, 0, 0, 0, ONE, 20'h10000);
		send(ONE, 0, 0, 0, 0, ONE, 20'h18000);
		send(46341, 0, -46341, 0, 0, ONE, 20'h16A0A);
		send(46341, 0, -46341, 0, 0, ONE, 20'h20000);
		send(46341, 0, -46341, 0, 0, ONE, 20'h0C000);
		send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'hFFFFF);
		send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 20'hFFFFF);
		send(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 20'h10000);
		send(32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0, 0, 20'h0);
		send(ONE, ONE, ONE, ONE, ONE, ONE, 20'h10000);
		send(32'h0100_0000, 0, 0, 32'h8000_0000, 0, 0, 20'h00001);
		send(-ONE, -ONE, -ONE, ONE, -ONE, ONE, 20'hFFFFF);
		send(32'hFFFF_FFFF, 1, 0, 1, 32'hFFFF_FFFF, 0, 20'h08000);

		// Random: mostly unit-scale rays, some full-range noise
		for (int i = 0; i < NUM_RANDOM; i++) begin
			if (i > NUM_RANDOM - 150) calm = 1'b1;
			nz = ($urandom_range(0, 1)) ? ONE : -ONE;
			if ($urandom_range(0, 3) == 0)
				send(rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
					rand_comp(), 20'($urandom()));
			else
				send(rand_comp(), rand_comp(), rand_comp(),
					32'(int'($urandom_range(0, 8192)) - 4096),
					32'(int'($urandom_range(0, 8192)) - 4096), nz,
					20'($urandom_range(0, 20'h30000)));
		end
		ray.valid <= 1'b0;

		// Drain, then allow the pipeline latency to pass
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("vector_refraction_tb OK");
		else
			$display("vector_refraction_tb NOT OK");
		$finish;
	end
endmodule
